// ===== hdl/srfc_pkg.sv =====
// Package for the sensor reply frame checker: item kinds, opcodes, frame
// constants, verdict and LED codes, and the structs passed between modules.
// No dependencies.
`timescale 1ns / 1ps

package srfc_pkg;

  // Kind of one queued item after classification by the front end.
  typedef enum logic [1:0] {
    KIND_CMD  = 2'd0,
    KIND_BYTE = 2'd1,
    KIND_LAST = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } op_t;

  typedef enum logic [2:0] {
    VERDICT_BAD_HEADER = 3'd0,
    VERDICT_SUCCESS    = 3'd1,
    VERDICT_FAILURE    = 3'd2,
    VERDICT_PROGRESS   = 3'd3,
    VERDICT_NO_ACTION  = 3'd4
  } verdict_t;

  typedef enum logic [1:0] {
    LED_NONE  = 2'd0,
    LED_GREEN = 2'd1,
    LED_RED   = 2'd2
  } led_t;

  typedef struct packed {
    verdict_t    verdict;
    led_t        led;
    logic        door;
    logic [15:0] id;
    logic [15:0] score;
    logic [7:0]  confirm;
  } res_t;

  // Command opcodes.
  localparam logic [7:0] OP_NONE       = 8'h00;
  localparam logic [7:0] OP_IDENTIFY   = 8'h32;
  localparam logic [7:0] OP_ENROLL     = 8'h31;
  localparam logic [7:0] OP_CANCEL     = 8'h30;
  localparam logic [7:0] OP_READ_INDEX = 8'h1F;
  localparam logic [7:0] OP_LED        = 8'h3C;

  // Frame layout.
  localparam logic [7:0] HDR_BYTE0      = 8'hEF;
  localparam logic [7:0] HDR_BYTE1      = 8'h01;
  localparam logic [7:0] STEP_FINAL     = 8'h06;
  localparam logic [7:0] STEP_ARG_FINAL = 8'hF2;
  localparam logic [7:0] LEN_IDENTIFY   = 8'd17;
  localparam logic [7:0] LEN_ENROLL     = 8'd14;
  localparam logic [7:0] LEN_CANCEL     = 8'd12;
  localparam logic [7:0] LEN_MIN        = 8'd2;
  localparam logic [7:0] SUM_START      = 8'd8;
  localparam logic [7:0] IDX_HDR0       = 8'd0;
  localparam logic [7:0] IDX_HDR1       = 8'd1;
  localparam logic [7:0] IDX_CONFIRM    = 8'd9;
  localparam logic [7:0] IDX_STEP_KIND  = 8'd10;
  localparam logic [7:0] IDX_ID_HI      = 8'd11;
  localparam logic [7:0] IDX_ID_LO      = 8'd12;
  localparam logic [7:0] IDX_SCORE_HI   = 8'd13;
  localparam logic [7:0] IDX_SCORE_LO   = 8'd14;
  localparam logic [7:0] COUNT_MAX      = 8'd255;

endpackage

// ===== hdl/srfc_front.sv =====
// Front end of the sensor reply frame checker: classifies each input item
// and holds it in a two-entry queue for the frame engine. Uses srfc_pkg.
`timescale 1ns / 1ps

module srfc_front
  import srfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       req_type,
  input  logic [7:0] cmd_code,
  input  logic [7:0] rx_byte,
  input  logic       rx_last,
  output logic       op_valid,
  input  logic       op_ready,
  output op_t        op
);

  op_t        q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  op_t        op_in;
  logic       push_ok;
  logic       pop_ok;

  always_comb begin
    if (!req_type) begin
      op_in.kind = KIND_CMD;
      op_in.data = cmd_code;
    end else begin
      op_in.kind = rx_last ? KIND_LAST : KIND_BYTE;
      op_in.data = rx_byte;
    end
  end

  assign full     = (count == 2'd2);
  assign op_valid = (count != 2'd0);
  assign op       = q[rd_ptr];
  assign push_ok  = push && !full;
  assign pop_ok   = op_valid && op_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_ok) wr_ptr <= ~wr_ptr;
      if (pop_ok) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push_ok} - {1'b0, pop_ok};
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) q[wr_ptr] <= op_in;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("front queue count out of range");

endmodule

// ===== hdl/srfc_back.sv =====
// Frame engine of the sensor reply frame checker: tracks the pending opcode,
// counts, sums and captures reply bytes, and judges each frame at its last
// byte. Uses srfc_pkg.
`timescale 1ns / 1ps

module srfc_back
  import srfc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic op_valid,
  output logic op_ready,
  input  op_t  op,
  output logic res_push,
  input  logic res_full,
  output res_t res
);

  logic [7:0]  pending_command;
  logic [7:0]  byte_count;
  logic [15:0] running_sum;
  logic        header_good;
  logic [7:0]  older_tail_byte;
  logic [7:0]  newer_tail_byte;
  logic [7:0]  confirm_capture;
  logic [7:0]  step_kind_capture;
  logic [7:0]  step_arg_capture;
  logic [15:0] id_capture;
  logic [15:0] score_capture;

  logic [7:0]  byte_count_next;
  logic [15:0] running_sum_next;
  logic        header_good_next;
  logic [7:0]  confirm_next;
  logic [7:0]  step_kind_next;
  logic [7:0]  step_arg_next;
  logic [15:0] id_next;
  logic [15:0] score_next;
  logic [7:0]  pending_next;
  logic        sum_ok;
  logic        take;
  logic [7:0]  b;

  assign b        = op.data;
  assign op_ready = (op.kind != KIND_LAST) || !res_full;
  assign take     = op_valid && op_ready;
  assign res_push = take && (op.kind == KIND_LAST);

  // Effect of the current byte on the frame state.
  always_comb begin
    running_sum_next = running_sum;
    if (byte_count >= SUM_START) running_sum_next = running_sum + {8'd0, older_tail_byte};
    header_good_next = header_good;
    if (byte_count == IDX_HDR0 && b != HDR_BYTE0) header_good_next = 1'b0;
    if (byte_count == IDX_HDR1 && b != HDR_BYTE1) header_good_next = 1'b0;
    confirm_next   = (byte_count == IDX_CONFIRM) ? b : confirm_capture;
    step_kind_next = (byte_count == IDX_STEP_KIND) ? b : step_kind_capture;
    step_arg_next  = (byte_count == IDX_ID_HI) ? b : step_arg_capture;
    id_next        = id_capture;
    if (byte_count == IDX_ID_HI) id_next = {b, 8'd0};
    if (byte_count == IDX_ID_LO) id_next = {id_capture[15:8], b};
    score_next     = score_capture;
    if (byte_count == IDX_SCORE_HI) score_next = {b, 8'd0};
    if (byte_count == IDX_SCORE_LO) score_next = {score_capture[15:8], b};
    byte_count_next = (byte_count < COUNT_MAX) ? byte_count + 8'd1 : byte_count;
  end

  // Verdict of a frame that ends with the current byte. The two tail bytes
  // after this byte are the old newer tail byte and the byte itself.
  always_comb begin
    sum_ok       = (running_sum_next == {newer_tail_byte, b});
    res.verdict  = VERDICT_NO_ACTION;
    res.led      = LED_NONE;
    res.door     = 1'b0;
    res.id       = 16'd0;
    res.score    = 16'd0;
    res.confirm  = confirm_next;
    pending_next = pending_command;
    if (!header_good_next || byte_count_next < LEN_MIN) begin
      res.verdict = VERDICT_BAD_HEADER;
    end else begin
      case (pending_command)
        OP_IDENTIFY: begin
          if (byte_count_next == LEN_IDENTIFY && sum_ok && confirm_next == 8'd0) begin
            res.verdict = VERDICT_SUCCESS;
            res.led     = LED_GREEN;
            res.door    = 1'b1;
            res.id      = id_next;
            res.score   = score_next;
          end else begin
            res.verdict = VERDICT_FAILURE;
            res.led     = LED_RED;
          end
        end
        OP_ENROLL: begin
          if (byte_count_next != LEN_ENROLL) begin
            res.verdict = VERDICT_FAILURE;
            res.led     = LED_RED;
          end else if (step_kind_next == STEP_FINAL && step_arg_next == STEP_ARG_FINAL) begin
            res.verdict = VERDICT_SUCCESS;
            res.led     = LED_GREEN;
          end else if (confirm_next == 8'd0) begin
            res.verdict = VERDICT_PROGRESS;
          end else begin
            res.verdict = VERDICT_FAILURE;
            res.led     = LED_RED;
          end
        end
        OP_CANCEL: begin
          if (byte_count_next == LEN_CANCEL) begin
            res.verdict = VERDICT_SUCCESS;
            res.led     = LED_GREEN;
          end else begin
            res.verdict = VERDICT_FAILURE;
          end
        end
        OP_READ_INDEX: begin
          if (sum_ok && confirm_next == 8'd0) begin
            res.verdict = VERDICT_SUCCESS;
            res.led     = LED_GREEN;
          end else begin
            res.verdict = VERDICT_FAILURE;
            res.led     = LED_RED;
          end
        end
        default: begin
          pending_next = OP_NONE;
        end
      endcase
    end
    if (res.led != LED_NONE) pending_next = OP_LED;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_command   <= OP_NONE;
      byte_count        <= 8'd0;
      running_sum       <= 16'd0;
      header_good       <= 1'b1;
      older_tail_byte   <= 8'd0;
      newer_tail_byte   <= 8'd0;
      confirm_capture   <= 8'd0;
      step_kind_capture <= 8'd0;
      step_arg_capture  <= 8'd0;
      id_capture        <= 16'd0;
      score_capture     <= 16'd0;
    end else if (take) begin
      case (op.kind)
        KIND_CMD: begin
          pending_command <= op.data;
        end
        KIND_BYTE: begin
          byte_count        <= byte_count_next;
          running_sum       <= running_sum_next;
          header_good       <= header_good_next;
          older_tail_byte   <= newer_tail_byte;
          newer_tail_byte   <= b;
          confirm_capture   <= confirm_next;
          step_kind_capture <= step_kind_next;
          step_arg_capture  <= step_arg_next;
          id_capture        <= id_next;
          score_capture     <= score_next;
        end
        KIND_LAST: begin
          pending_command   <= pending_next;
          byte_count        <= 8'd0;
          running_sum       <= 16'd0;
          header_good       <= 1'b1;
          older_tail_byte   <= 8'd0;
          newer_tail_byte   <= 8'd0;
          confirm_capture   <= 8'd0;
          step_kind_capture <= 8'd0;
          step_arg_capture  <= 8'd0;
          id_capture        <= 16'd0;
          score_capture     <= 16'd0;
        end
        default: begin
          pending_command <= pending_command;
        end
      endcase
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_door_needs_success: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.door) |-> (res.verdict == VERDICT_SUCCESS && res.led == LED_GREEN))
    else $error("door opened without identify success");

  a_frame_cleared: assert property (@(posedge clk) disable iff (rst)
    res_push |=> (byte_count == 8'd0 && running_sum == 16'd0 && header_good))
    else $error("frame state not cleared after last byte");

  a_led_sets_pending: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.led != LED_NONE) |=> (pending_command == OP_LED))
    else $error("LED command did not become pending");

endmodule

// ===== hdl/srfc_out_queue.sv =====
// Result queue of the sensor reply frame checker: two entries between the
// frame engine and the result ports. Uses srfc_pkg.
`timescale 1ns / 1ps

module srfc_out_queue
  import srfc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic res_push,
  output logic res_full,
  input  res_t res_in,
  output logic empty,
  input  logic pop,
  output res_t res_out
);

  res_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop_ok;

  assign res_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign res_out  = q[rd_ptr];
  assign pop_ok   = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (res_push) wr_ptr <= ~wr_ptr;
      if (pop_ok) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, res_push} - {1'b0, pop_ok};
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) q[wr_ptr] <= res_in;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("result queue count out of range");

endmodule

// ===== hdl/sensor_reply_frame_checker.sv =====
// Top level of the sensor reply frame checker: front end, frame engine and
// result queue. Uses srfc_pkg, srfc_front, srfc_back and srfc_out_queue.
//
//   Channel   Handshake     Fields
//   input     push / full   req_type, cmd_code, rx_byte, rx_last
//   result    empty / pop   verdict, led_action, door_open, matched_id, match_score, reply_confirm
//
// The block takes one item per cycle when neither side stalls.
// An accepted item is held in the input queue before the frame engine handles it, and the
// result for the last byte of a frame is registered in the result queue, whose head drives
// the result ports; the result can be popped from there.
// The synchronous reset returns the pending opcode and all frame state to
// their idle values and empties both queues.
// When the result side stalls, the two-entry result queue fills, the frame engine holds a
// last byte at the head of the input queue, and full rises once one more item has
// been queued behind it.
`timescale 1ns / 1ps

module sensor_reply_frame_checker
  import srfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        req_type,
  input  logic [7:0]  cmd_code,
  input  logic [7:0]  rx_byte,
  input  logic        rx_last,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  verdict,
  output logic [1:0]  led_action,
  output logic        door_open,
  output logic [15:0] matched_id,
  output logic [15:0] match_score,
  output logic [7:0]  reply_confirm
);

  // Classified items travel from the front end to the frame engine.
  logic op_valid;
  logic op_ready;
  op_t  op;

  // Judged frames travel from the frame engine to the result queue.
  logic res_push;
  logic res_full;
  res_t res_in;
  res_t res_out;

  srfc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .req_type (req_type),
    .cmd_code (cmd_code),
    .rx_byte  (rx_byte),
    .rx_last  (rx_last),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .op       (op)
  );

  srfc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .op       (op),
    .res_push (res_push),
    .res_full (res_full),
    .res      (res_in)
  );

  srfc_out_queue u_out_queue (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res_full (res_full),
    .res_in   (res_in),
    .empty    (empty),
    .pop      (pop),
    .res_out  (res_out)
  );

  // The head of the result queue drives the result ports directly.
  assign verdict       = res_out.verdict;
  assign led_action    = res_out.led;
  assign door_open     = res_out.door;
  assign matched_id    = res_out.id;
  assign match_score   = res_out.score;
  assign reply_confirm = res_out.confirm;

endmodule
